// ===== hw/rtl/motor_command_controller_assert.svh =====
// assertion helpers for the motor command controller
`ifndef MOTOR_COMMAND_CONTROLLER_ASSERT_SVH
`define MOTOR_COMMAND_CONTROLLER_ASSERT_SVH

// expression must hold at every edge out of reset
`define MCC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define MCC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mcc_pkg.sv =====
package mcc_pkg;

  localparam int FrameLen = 8;
  localparam int HeadLen  = FrameLen - 1;
  localparam int PosW     = $clog2(FrameLen);

  localparam int MaxSpeed = 100;
  localparam int MaxAngle = 45;

  // floor(x/100) for x up to 255*100 as (x*DutyRecip) >> DutyShift
  localparam int DutyShift = 24;
  localparam logic [17:0] DutyRecip = 18'd167773;

  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChOne  = 8'h31;
  localparam logic [7:0] ChFour = 8'h34;
  localparam logic [7:0] ChFive = 8'h35;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChB    = 8'h42;
  localparam logic [7:0] ChE    = 8'h45;
  localparam logic [7:0] ChF    = 8'h46;
  localparam logic [7:0] ChL    = 8'h4C;
  localparam logic [7:0] ChR    = 8'h52;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BWD  = 2'd2
  } dc_dir_t;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_R    = 2'd1,
    STEP_L    = 2'd2
  } step_dir_t;

  typedef logic [HeadLen-1:0][7:0] head_t;

  typedef struct packed {
    logic       valid;
    logic [6:0] speed;
    dc_dir_t    dc_dir;
    logic [5:0] steps;
    step_dir_t  step_dir;
  } frame_dec_t;

  // half-step coil sequence, nine entries so both walk directions index directly
  function automatic logic [3:0] coil_lookup(input logic [3:0] idx);
    logic [3:0] pat;
    case (idx)
      4'd0:    pat = 4'd6;
      4'd1:    pat = 4'd2;
      4'd2:    pat = 4'd3;
      4'd3:    pat = 4'd1;
      4'd4:    pat = 4'd9;
      4'd5:    pat = 4'd8;
      4'd6:    pat = 4'd12;
      4'd7:    pat = 4'd4;
      4'd8:    pat = 4'd6;
      default: pat = 4'd0;
    endcase
    return pat;
  endfunction

endpackage

// ===== hw/rtl/mcc_frame_check.sv =====
module mcc_frame_check (
  input  mcc_pkg::head_t      head,
  input  logic [7:0]          last_byte,
  output mcc_pkg::frame_dec_t dec
);
  import mcc_pkg::*;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  logic       fmt_ok;
  logic       angle_ok;
  logic [3:0] tens;
  logic [3:0] ones;
  logic [3:0] adig_hi;
  logic [3:0] adig_lo;
  logic [7:0] speed_raw;
  logic [6:0] angle_raw;

  assign tens    = head[1][3:0];
  assign ones    = head[2][3:0];
  assign adig_hi = head[4][3:0];
  assign adig_lo = head[5][3:0];

  always_comb begin
    fmt_ok = (last_byte == ChE)
          && (head[0] == ChZero || head[0] == ChOne)
          && is_digit(head[1]) && is_digit(head[2])
          && (head[3] == ChF || head[3] == ChB)
          && is_digit(head[4]) && is_digit(head[5])
          && (head[6] == ChR || head[6] == ChL);
    angle_ok = (head[4] < ChFour) || (head[4] == ChFour && head[5] <= ChFive);
  end

  // digits are known good when the result is used, so the low nibble is the value
  always_comb begin
    speed_raw = (head[0][0] ? 8'd100 : 8'd0)
              + {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0}
              + {4'b0000, ones};
    angle_raw = {adig_hi, 3'b000} + {2'b00, adig_hi, 1'b0} + {3'b000, adig_lo};
  end

  always_comb begin
    dec.valid    = fmt_ok && angle_ok;
    dec.speed    = (speed_raw > 8'(MaxSpeed)) ? 7'(MaxSpeed) : speed_raw[6:0];
    dec.dc_dir   = (head[3] == ChF) ? DIR_FWD : DIR_BWD;
    dec.steps    = angle_raw[5:0];
    dec.step_dir = (head[6] == ChR) ? STEP_R : STEP_L;
  end

endmodule

// ===== hw/rtl/motor_command_controller.sv =====
// channel | ports                                   | direction
// --------+-----------------------------------------+----------
// input   | in_valid in_ready in_req_type in_rx_byte | in
// result  | out_valid out_ready out_pwm_duty         | out
//         | out_drive_forward out_drive_backward     |
//         | out_coil_pattern out_frame_error         |
//         | out_frame_accepted                       |
// one item per cycle sustained while out_ready stays high; each result passes through
// the input register, then the result register, with one pass of frame check and duty scaling
// reset is synchronous and clears the byte position, motor settings, phase and coils
// a stalled result holds in the result register while the input register takes one more
// item; in_ready drops only when both registers are full and out_ready is low
module motor_command_controller (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_req_type,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_pwm_duty,
  output logic       out_drive_forward,
  output logic       out_drive_backward,
  output logic [3:0] out_coil_pattern,
  output logic       out_frame_error,
  output logic       out_frame_accepted
);
  import mcc_pkg::*;

  localparam logic [PosW-1:0] LastPos = PosW'(FrameLen - 1);

  // input register
  logic       in_valid_r;
  logic       in_req_r;
  logic [7:0] in_byte_r;

  // block state
  head_t           head_r;
  logic [PosW-1:0] pos_r, pos_nxt;
  logic [6:0]      speed_r, speed_nxt;
  dc_dir_t         dc_dir_r, dc_dir_nxt;
  logic [5:0]      steps_r, steps_nxt;
  step_dir_t       step_dir_r, step_dir_nxt;
  logic [2:0]      phase_r, phase_nxt;
  logic [3:0]      coil_r, coil_nxt;

  // result register
  logic       out_valid_r;
  logic [7:0] duty_r;
  logic       fwd_r;
  logic       bwd_r;
  logic [3:0] coil_out_r;
  logic       err_r;
  logic       acc_r;

  logic       advance;
  logic       frame_done;
  logic       step_fire;
  logic [3:0] coil_idx;
  logic [14:0] duty_prod;
  logic [32:0] duty_scaled;
  logic [7:0]  duty_nxt;
  frame_dec_t  dec;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_req_r  <= in_req_type;
      in_byte_r <= in_rx_byte;
    end
  end

  mcc_frame_check u_check (
    .head      (head_r),
    .last_byte (in_byte_r),
    .dec       (dec)
  );

  assign frame_done = !in_req_r && (pos_r == LastPos);
  assign step_fire  = in_req_r && (steps_r != 6'd0)
                   && (step_dir_r == STEP_R || step_dir_r == STEP_L);
  // right walks entries one to eight, left walks seven down to zero
  assign coil_idx   = (step_dir_r == STEP_R) ? ({1'b0, phase_r} + 4'd1)
                                             : {1'b0, ~phase_r};

  always_comb begin
    pos_nxt      = pos_r;
    speed_nxt    = speed_r;
    dc_dir_nxt   = dc_dir_r;
    steps_nxt    = steps_r;
    step_dir_nxt = step_dir_r;
    phase_nxt    = phase_r;
    coil_nxt     = coil_r;
    if (!in_req_r) begin
      pos_nxt = pos_r + PosW'(1);
      if (frame_done && dec.valid) begin
        speed_nxt    = dec.speed;
        dc_dir_nxt   = dec.dc_dir;
        steps_nxt    = dec.steps;
        step_dir_nxt = dec.step_dir;
      end
    end else if (step_fire) begin
      steps_nxt = steps_r - 6'd1;
      coil_nxt  = coil_lookup(coil_idx);
      phase_nxt = phase_r + 3'd1;
    end
  end

  // duty = speed*255/100, truncated
  assign duty_prod   = {speed_nxt, 8'h00} - {8'h00, speed_nxt};
  assign duty_scaled = {18'd0, duty_prod} * {15'd0, DutyRecip};
  assign duty_nxt    = duty_scaled[DutyShift +: 8];

  always_ff @(posedge clk) begin
    if (advance && !frame_done && !in_req_r) begin
      head_r[pos_r] <= in_byte_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      speed_r    <= '0;
      dc_dir_r   <= DIR_NONE;
      steps_r    <= '0;
      step_dir_r <= STEP_NONE;
      phase_r    <= '0;
      coil_r     <= '0;
    end else if (advance) begin
      pos_r      <= pos_nxt;
      speed_r    <= speed_nxt;
      dc_dir_r   <= dc_dir_nxt;
      steps_r    <= steps_nxt;
      step_dir_r <= step_dir_nxt;
      phase_r    <= phase_nxt;
      coil_r     <= coil_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      duty_r     <= duty_nxt;
      fwd_r      <= (dc_dir_nxt == DIR_FWD);
      bwd_r      <= (dc_dir_nxt == DIR_BWD);
      coil_out_r <= coil_nxt;
      err_r      <= frame_done && !dec.valid;
      acc_r      <= frame_done && dec.valid;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pwm_duty       = duty_r;
  assign out_drive_forward  = fwd_r;
  assign out_drive_backward = bwd_r;
  assign out_coil_pattern   = coil_out_r;
  assign out_frame_error    = err_r;
  assign out_frame_accepted = acc_r;

`include "motor_command_controller_assert.svh"

  `MCC_ASSERT_ALWAYS(a_steps_range, steps_r <= 6'(MaxAngle), "step count beyond angle limit")
  `MCC_ASSERT_ALWAYS(a_speed_range, speed_r <= 7'(MaxSpeed), "speed beyond saturation limit")
  `MCC_ASSERT_IMPLY(a_flags_excl, out_valid_r, !(err_r && acc_r), "both frame flags set")
  `MCC_ASSERT_IMPLY(a_stall_cause, !in_ready, in_valid_r && out_valid_r && !out_ready, "bad stall")

endmodule
